// ===== rtl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// shared codes for the cartridge bank mapper: item functions, write decode
// addresses and bank command numbers
// ----------------------------------------------------------------------------
package cbm_pkg;

  typedef enum logic [1:0] {
    FUNC_CPU_WRITE  = 2'd0,
    FUNC_SCANLINE   = 2'd1,
    FUNC_PATTERN_LU = 2'd2,
    FUNC_PROGRAM_LU = 2'd3
  } func_t;

  localparam logic [15:0] DECODE_MASK  = 16'hF003;
  localparam logic [15:0] ADDR_MIRROR  = 16'h8001;
  localparam logic [15:0] ADDR_COMMAND = 16'hA000;
  localparam logic [15:0] ADDR_BANK    = 16'hC000;
  localparam logic [15:0] ADDR_IRQ     = 16'hE003;

  // bank command numbers latched by a command write
  localparam logic [2:0] CMD_CHR_2K_0 = 3'd0;
  localparam logic [2:0] CMD_CHR_1K_5 = 3'd1;
  localparam logic [2:0] CMD_CHR_2K_2 = 3'd2;
  localparam logic [2:0] CMD_CHR_1K_7 = 3'd3;
  localparam logic [2:0] CMD_PRG_0    = 3'd4;
  localparam logic [2:0] CMD_PRG_1    = 3'd5;
  localparam logic [2:0] CMD_CHR_1K_4 = 3'd6;
  localparam logic [2:0] CMD_CHR_1K_6 = 3'd7;

  localparam int unsigned MAP_W = 21;

endpackage

// ===== rtl/cartridge_bank_mapper_with_scanline_irq_core.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq_core
// bank mapper with scanline interrupt counter, one word in, one word out
// ----------------------------------------------------------------------------
// usage:
//   the input channel carries one word per cpu write, scanline tick, pattern
//   lookup or program lookup (in_func selects which). every input word gives
//   exactly one output word: the translated rom address for a lookup plus the
//   interrupt level and mirroring mode as they stand after that word.
//   path: an accepted word sits in the input register, is processed and
//   lands in the output register, where it is offered on out_valid until taken.
//   throughput: one word per cycle unless the output word is stalled, set by
//   the single pass of decode and bank selection between the two registers.
//   stalls: while the output word is stalled the input register still takes
//   one more word, so the sender sees in_stall only when both are full.
//   reset: rst_n low (synchronous) empties both registers and clears all
//   bank registers, the command latch, mirroring (vertical) and the counter.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [15:0]              in_address,
  input  logic [7:0]               in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [cbm_pkg::MAP_W-1:0] out_mapped_address,
  output logic                     out_mapped_valid,
  output logic                     out_irq_line,
  output logic                     out_mirror_horizontal
);
  import cbm_pkg::*;

  // input register
  logic        in_valid_r;
  func_t       func_r;
  logic [15:0] address_r;
  logic [7:0]  data_r;

  // mapper state
  logic [2:0]  command_r, command_nxt;
  logic [7:0]  chr_bank_r [6];
  logic [7:0]  chr_bank_nxt [6];
  logic [7:0]  prg_bank_r [2];
  logic [7:0]  prg_bank_nxt [2];
  logic        mirror_r, mirror_nxt;
  logic [7:0]  irq_count_r, irq_count_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic        irq_pend_r, irq_pend_nxt;

  // output register
  logic             out_valid_r;
  logic [MAP_W-1:0] map_addr_r, map_addr_nxt;
  logic             map_valid_r, map_valid_nxt;
  logic             irq_line_r;
  logic             mirror_out_r;

  logic        advance;
  logic        take_in;
  logic [15:0] dec_addr;

  // the input register moves on whenever the output register is free
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;
  assign dec_addr = address_r & DECODE_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take_in) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r    <= FUNC_CPU_WRITE;
      address_r <= '0;
      data_r    <= '0;
    end else if (take_in) begin
      func_r    <= func_t'(in_func);
      address_r <= in_address;
      data_r    <= in_data;
    end
  end

  // state update and translation for the word in the input register
  always_comb begin
    command_nxt   = command_r;
    chr_bank_nxt  = chr_bank_r;
    prg_bank_nxt  = prg_bank_r;
    mirror_nxt    = mirror_r;
    irq_count_nxt = irq_count_r;
    irq_en_nxt    = irq_en_r;
    irq_pend_nxt  = irq_pend_r;
    map_addr_nxt  = '0;
    map_valid_nxt = 1'b0;

    unique case (func_r)
      FUNC_CPU_WRITE: begin
        priority if (dec_addr == ADDR_MIRROR) begin
          mirror_nxt = data_r[0];
        end else if (dec_addr == ADDR_COMMAND) begin
          command_nxt = data_r[2:0];
        end else if (dec_addr == ADDR_BANK) begin
          unique case (command_r)
            CMD_CHR_2K_0: chr_bank_nxt[0] = data_r;
            CMD_CHR_1K_5: chr_bank_nxt[1] = data_r;
            CMD_CHR_2K_2: chr_bank_nxt[2] = data_r;
            CMD_CHR_1K_7: chr_bank_nxt[3] = data_r;
            CMD_PRG_0:    prg_bank_nxt[0] = data_r;
            CMD_PRG_1:    prg_bank_nxt[1] = data_r;
            CMD_CHR_1K_4: chr_bank_nxt[4] = data_r;
            CMD_CHR_1K_6: chr_bank_nxt[5] = data_r;
          endcase
        end else if (dec_addr == ADDR_IRQ) begin
          irq_pend_nxt  = 1'b0;
          irq_count_nxt = data_r;
          irq_en_nxt    = (data_r != 8'd0);
        end else begin
          // undecoded write, ignored
        end
      end
      FUNC_SCANLINE: begin
        if (irq_en_r) begin
          if (irq_count_r == 8'd0) begin
            irq_en_nxt   = 1'b0;
            irq_pend_nxt = 1'b1;
          end else begin
            irq_count_nxt = irq_count_r - 8'd1;
          end
        end
      end
      FUNC_PATTERN_LU: begin
        if (address_r[15:13] == 3'b000) begin
          map_valid_nxt = 1'b1;
          unique case (address_r[12:10])
            3'd0, 3'd1: map_addr_nxt = {3'b000, chr_bank_r[0][7:1], address_r[10:0]};
            3'd2, 3'd3: map_addr_nxt = {3'b000, chr_bank_r[2][7:1], address_r[10:0]};
            3'd4:       map_addr_nxt = {3'b000, chr_bank_r[4], address_r[9:0]};
            3'd5:       map_addr_nxt = {3'b000, chr_bank_r[1], address_r[9:0]};
            3'd6:       map_addr_nxt = {3'b000, chr_bank_r[5], address_r[9:0]};
            3'd7:       map_addr_nxt = {3'b000, chr_bank_r[3], address_r[9:0]};
          endcase
        end
      end
      FUNC_PROGRAM_LU: begin
        // only the two 8k windows from 0x8000 to 0xbfff are mapped here
        if (address_r[15:14] == 2'b10) begin
          map_valid_nxt = 1'b1;
          map_addr_nxt  = address_r[13] ? {prg_bank_r[1], address_r[12:0]}
                                        : {prg_bank_r[0], address_r[12:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r   <= '0;
      chr_bank_r  <= '{default: '0};
      prg_bank_r  <= '{default: '0};
      mirror_r    <= 1'b0;
      irq_count_r <= '0;
      irq_en_r    <= 1'b0;
      irq_pend_r  <= 1'b0;
    end else if (in_valid_r && advance) begin
      command_r   <= command_nxt;
      chr_bank_r  <= chr_bank_nxt;
      prg_bank_r  <= prg_bank_nxt;
      mirror_r    <= mirror_nxt;
      irq_count_r <= irq_count_nxt;
      irq_en_r    <= irq_en_nxt;
      irq_pend_r  <= irq_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      map_addr_r   <= map_addr_nxt;
      map_valid_r  <= map_valid_nxt;
      irq_line_r   <= irq_pend_nxt;
      mirror_out_r <= mirror_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mapped_address    = map_addr_r;
  assign out_mapped_valid      = map_valid_r;
  assign out_irq_line          = irq_line_r;
  assign out_mirror_horizontal = mirror_out_r;

endmodule

// ===== rtl/cbm_checker.sv =====
// ----------------------------------------------------------------------------
// cbm_checker
// port-level checks on the bank mapper, bound to the top level
// ----------------------------------------------------------------------------
module cbm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [cbm_pkg::MAP_W-1:0] out_mapped_address,
  input logic                      out_mapped_valid,
  input logic                      out_irq_line,
  input logic                      out_mirror_horizontal
);
  import cbm_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mapped_address)
      && $stable(out_mapped_valid) && $stable(out_irq_line)
      && $stable(out_mirror_horizontal))
    else $error("stalled output word changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a miss or a non-lookup word carries a zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mapped_valid |-> out_mapped_address == '0)
    else $error("nonzero address on a miss");

  // input side stalls only when the output side holds a stalled word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind cartridge_bank_mapper_with_scanline_irq_core cbm_checker u_cbm_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_mapped_address    (out_mapped_address),
  .out_mapped_valid      (out_mapped_valid),
  .out_irq_line          (out_irq_line),
  .out_mirror_horizontal (out_mirror_horizontal)
);

// ===== sim/cartridge_bank_mapper_with_scanline_irq_core_tb.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq_core_tb
// self-checking bench for the bank mapper with scanline interrupt counter
// a queue of bus words (cpu writes, scanline ticks, pattern and program
// lookups) feeds a clocked driver; every accepted word runs through a local
// model of the mapper, and the monitor checks each output word against the
// oldest predicted one. sender bursts and receiver stalls vary all run long
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq_core_tb;
  import cbm_pkg::*;

  // address windows seen by the lookups
  localparam logic [15:0] PATTERN_TOP  = 16'h2000;
  localparam logic [15:0] PROGRAM_BASE = 16'h8000;
  localparam logic [15:0] PROGRAM_HIGH = 16'hA000;
  localparam logic [15:0] PROGRAM_TOP  = 16'hC000;
  // address bits that the write decode ignores
  localparam logic [15:0] ALIAS_BITS   = ~DECODE_MASK;
  localparam int          RANDOM_WORDS = 1600;

  typedef struct {
    func_t       fn;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          drain_first;  // sender waits for all results before this word
  } bus_word_t;

  typedef struct {
    logic [MAP_W-1:0] rom_addr;
    logic             hit;
    logic             irq;
    logic             mirror_h;
  } map_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_func = 2'd0;
  logic [15:0]         in_address = 16'd0;
  logic [7:0]          in_data = 8'd0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MAP_W-1:0]    out_mapped_address;
  logic                out_mapped_valid;
  logic                out_irq_line;
  logic                out_mirror_horizontal;

  cartridge_bank_mapper_with_scanline_irq_core DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // mapper model: command latch, eight bank registers indexed by command
  // number, mirroring, and the scanline counter
  // --------------------------------------------------------------------------
  logic [2:0] cmd_sel = '0;
  logic [7:0] bank_reg [8] = '{default: 8'h00};
  logic       mirror_h = 1'b0;
  logic [7:0] irq_cnt = '0;
  logic       irq_en = 1'b0;
  logic       irq_pend = 1'b0;

  int irqs_raised = 0;
  int lookups_hit = 0;

  function automatic map_result_t apply_bus_word(input func_t fn, input logic [15:0] a,
                                                 input logic [7:0] d);
    map_result_t r;
    logic [7:0]  bank;
    r = '{default: '0};
    case (fn)
      FUNC_CPU_WRITE: begin
        // only four decoded addresses do anything, the rest are dropped
        case (a & DECODE_MASK)
          ADDR_MIRROR:  mirror_h = d[0];
          ADDR_COMMAND: cmd_sel = d[2:0];
          ADDR_BANK:    bank_reg[cmd_sel] = d;
          ADDR_IRQ: begin
            // counter load rearms only for a nonzero count and drops the line
            irq_pend = 1'b0;
            irq_cnt = d;
            irq_en = (d != 8'd0);
          end
          default: ;
        endcase
      end
      FUNC_SCANLINE: begin
        // tick at zero count fires once and disarms; disabled tick is a no-op
        if (irq_en) begin
          if (irq_cnt == 8'd0) begin
            irq_en = 1'b0;
            irq_pend = 1'b1;
            irqs_raised++;
          end else begin
            irq_cnt = irq_cnt - 8'd1;
          end
        end
      end
      FUNC_PATTERN_LU: begin
        if (a < PATTERN_TOP) begin
          r.hit = 1'b1;
          // two 2k windows, then four 1k windows
          case (a[12:10])
            3'd0, 3'd1: r.rom_addr = {3'b000, bank_reg[CMD_CHR_2K_0][7:1], a[10:0]};
            3'd2, 3'd3: r.rom_addr = {3'b000, bank_reg[CMD_CHR_2K_2][7:1], a[10:0]};
            3'd4:       r.rom_addr = {3'b000, bank_reg[CMD_CHR_1K_4], a[9:0]};
            3'd5:       r.rom_addr = {3'b000, bank_reg[CMD_CHR_1K_5], a[9:0]};
            3'd6:       r.rom_addr = {3'b000, bank_reg[CMD_CHR_1K_6], a[9:0]};
            default:    r.rom_addr = {3'b000, bank_reg[CMD_CHR_1K_7], a[9:0]};
          endcase
        end
      end
      default: begin
        // program lookup: two 8k windows, the fixed window above is unmapped
        if (a >= PROGRAM_BASE && a < PROGRAM_TOP) begin
          r.hit = 1'b1;
          bank = (a >= PROGRAM_HIGH) ? bank_reg[CMD_PRG_1] : bank_reg[CMD_PRG_0];
          r.rom_addr = {bank, a[12:0]};
        end
      end
    endcase
    if (r.hit) lookups_hit++;
    r.irq = irq_pend;
    r.mirror_h = mirror_h;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus queue and the bookkeeping shared by the processes
  // --------------------------------------------------------------------------
  bus_word_t   feed_q[$];
  map_result_t due_results[$];
  bit          drain_next = 1'b0;
  logic        in_taken = 1'b0;
  int          words_in = 0;
  int          results_checked = 0;
  int          failures = 0;
  int          backpressure_cycles = 0;
  int          long_holds = 0;

  task automatic push_word(input func_t fn, input logic [15:0] a, input logic [7:0] d);
    bus_word_t w;
    w.fn = fn;
    w.addr = a;
    w.data = d;
    w.drain_first = drain_next;
    drain_next = 1'b0;
    feed_q.push_back(w);
  endtask

  // decoded write address with random don't-care bits
  function automatic logic [15:0] alias_of(input logic [15:0] base);
    return base | (16'($urandom) & ALIAS_BITS);
  endfunction

  // --------------------------------------------------------------------------
  // driver: bursts of back-to-back words with random gaps; a stalled word
  // holds still, and a word marked drain_first waits for an empty pipeline
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    bus_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (feed_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (feed_q[0].drain_first && due_results.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        w = feed_q.pop_front();
        in_valid <= 1'b1;
        in_func <= w.fn;
        in_address <= w.addr;
        in_data <= w.data;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          // half the bursts follow straight on, the rest after a short or long gap
          case ($urandom_range(0, 3))
            0, 1: gap_left = 0;
            2:    gap_left = $urandom_range(1, 3);
            default: gap_left = $urandom_range(4, 12);
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern switches mode every so often; at fixed word counts
  // it holds off for a long stretch so the block fills and pushes back
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int hold_marks[$] = '{150, 700, 1300};

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_marks.size() != 0 && words_in >= hold_marks[0]) begin
        void'(hold_marks.pop_front());
        hold_left = 80;
        long_holds++;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check the output word first, then predict the input word taken
  // at the same edge, so a fresh prediction never pairs with an older result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    map_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          if (failures < 10)
            $display("unexpected output word: addr %h hit %b irq %b mirror %b",
                     out_mapped_address, out_mapped_valid, out_irq_line,
                     out_mirror_horizontal);
          failures++;
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (out_mapped_address !== want.rom_addr || out_mapped_valid !== want.hit ||
              out_irq_line !== want.irq || out_mirror_horizontal !== want.mirror_h) begin
            if (failures < 10)
              $display("mismatch on result %0d: addr %h/%h hit %b/%b irq %b/%b mirror %b/%b",
                       results_checked, want.rom_addr, out_mapped_address, want.hit,
                       out_mapped_valid, want.irq, out_irq_line, want.mirror_h,
                       out_mirror_horizontal);
            failures++;
          end
        end
      end
      if (in_valid && in_stall) backpressure_cycles++;
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_bus_word(func_t'(in_func), in_address, in_data));
        words_in++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus: directed words first, then random well-formed sequences with
  // some noise; finally wait for the pipeline to drain and report
  // --------------------------------------------------------------------------
  initial begin
    int          first_random;
    int          d;
    int          n;
    logic [15:0] a;

    // every command, each followed by a bank write
    for (int c = 0; c < 8; c++) begin
      push_word(FUNC_CPU_WRITE, ADDR_COMMAND, {5'b11111, 3'(c)});
      push_word(FUNC_CPU_WRITE, ADDR_BANK, 8'hFF - 8'(c));
    end
    // lookups at the window edges, hits and misses
    push_word(FUNC_PATTERN_LU, 16'h0000, 8'h00);
    push_word(FUNC_PATTERN_LU, 16'h1FFF, 8'hFF);
    push_word(FUNC_PATTERN_LU, PATTERN_TOP, 8'h00);
    push_word(FUNC_PROGRAM_LU, PROGRAM_BASE, 8'h00);
    push_word(FUNC_PROGRAM_LU, 16'hBFFF, 8'hFF);
    push_word(FUNC_PROGRAM_LU, PROGRAM_TOP, 8'h00);
    // mirroring, then a write that decodes to nothing
    push_word(FUNC_CPU_WRITE, ADDR_MIRROR, 8'hFF);
    push_word(FUNC_CPU_WRITE, 16'hFFFF, 8'hFF);
    // counter: count down, fire at zero, tick while disarmed, reload clears
    push_word(FUNC_CPU_WRITE, ADDR_IRQ, 8'h01);
    push_word(FUNC_SCANLINE, 16'h0000, 8'h00);
    push_word(FUNC_SCANLINE, 16'hFFFF, 8'hFF);
    push_word(FUNC_SCANLINE, 16'h0000, 8'h00);
    push_word(FUNC_CPU_WRITE, ADDR_IRQ, 8'h00);

    // random part starts only once the directed results are all in
    drain_next = 1'b1;
    first_random = feed_q.size();
    while (feed_q.size() - first_random < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          // pick a bank register, load it, and usually look through it
          push_word(FUNC_CPU_WRITE, alias_of(ADDR_COMMAND), 8'($urandom));
          push_word(FUNC_CPU_WRITE, alias_of(ADDR_BANK), 8'($urandom));
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0)
              push_word(FUNC_PATTERN_LU, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
            else
              push_word(FUNC_PROGRAM_LU, 16'($urandom_range(16'h8000, 16'hBFFF)),
                        8'($urandom));
          end
        end
        5, 6: push_word(FUNC_CPU_WRITE, alias_of(ADDR_MIRROR), 8'($urandom));
        7, 8: begin
          // counter load and a run of ticks, some long enough to fire
          d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
          push_word(FUNC_CPU_WRITE, alias_of(ADDR_IRQ), 8'(d));
          n = $urandom_range(0, ((d > 16) ? 16 : d) + 3);
          for (int i = 0; i < n; i++)
            push_word(FUNC_SCANLINE, 16'($urandom), 8'($urandom));
        end
        9, 10, 11, 12: begin
          a = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h1FFF));
          push_word(FUNC_PATTERN_LU, a, 8'($urandom));
        end
        13, 14, 15: begin
          a = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(16'h8000, 16'hBFFF));
          push_word(FUNC_PROGRAM_LU, a, 8'($urandom));
        end
        16, 17: push_word(FUNC_CPU_WRITE, 16'($urandom), 8'($urandom));
        default: push_word(func_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      endcase
    end

    // synchronous reset, released at a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // everything sent and every result back, then a few spare cycles
    // to catch stray output words
    while (feed_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("summary: %0d words in, %0d results checked, %0d lookups mapped, %0d irqs raised",
             words_in, results_checked, lookups_hit, irqs_raised);
    $display("summary: %0d long receiver hold-offs, %0d cycles of input back-pressure",
             long_holds, backpressure_cycles);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d failures", failures);
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #1600000;
    $display("timeout after %0d words in, %0d results checked", words_in, results_checked);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cbm_pkg.sv
rtl/cartridge_bank_mapper_with_scanline_irq_core.sv
rtl/cbm_checker.sv
sim/cartridge_bank_mapper_with_scanline_irq_core_tb.sv
